/* rtl/cff_pkg.sv */
// shared types, constants and a helper function for the circle fill framebuffer
package cff_pkg;

    // default geometry and fixed point format
    localparam int FB_WIDTH_DEF  = 64;
    localparam int FB_HEIGHT_DEF = 64;
    localparam int FRAC_BITS_DEF = 4;

    // field widths of the stream items
    localparam int CENTER_W = 13;
    localparam int RADIUS_W = 10;
    localparam int COLUMN_W = 6;
    localparam int ROWP_W   = 5;
    localparam int OPCODE_W = 2;
    localparam int CHAR_W   = 8;
    localparam int BITS_W   = 2;

    localparam int RADIUS_MAX = (1 << RADIUS_W) - 1;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 10'd256;

    // command codes
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_DRAW  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

    // character codes for a cell
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CH_UNDER = 8'd95;
    localparam logic [CHAR_W-1:0] CH_CARET = 8'd94;
    localparam logic [CHAR_W-1:0] CH_FULL  = 8'd67;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_DRAW_SETUP,
        S_DRAW_CHECK,
        S_ROW_RD,
        S_ROW_LOAD,
        S_ROW_SCAN,
        S_ROW_WB,
        S_RD_TOP,
        S_RD_BOT,
        S_RD_LAST,
        S_DONE
    } t_state;

    // memory port strobes
    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

    // top pixel in bit 1, bottom pixel in bit 0
    function automatic logic [CHAR_W-1:0] cell_char(input logic [BITS_W-1:0] bits);
        logic [CHAR_W-1:0] ch;
        case (bits)
            2'd0:    ch = CH_SPACE;
            2'd1:    ch = CH_UNDER;
            2'd2:    ch = CH_CARET;
            2'd3:    ch = CH_FULL;
            default: ch = CH_SPACE;
        endcase
        return ch;
    endfunction

endpackage

/* rtl/circle_fill_framebuffer.sv */
// top level: command sequencer, circle scan and cell read around the frame store
//
// One-bit-per-pixel frame store of FB_WIDTH x FB_HEIGHT pixels, held as one
// row-wide memory. Commands arrive on the s_axis channel (opcode in tuser);
// every command gives exactly one item on the m_axis channel, all zero except
// for a read, which returns the cell character and its two pixel bits.
// Radius is set through i_cfg_we / i_cfg_wdata; the user must write it only
// while the block is idle, which the block itself does not enforce. Per item:
//   clear : one memory row written per cycle over every row of the store
//   draw  : over the clipped bounding box, one pixel a cycle through the
//           distance unit plus a read and a write-back per row; no row is
//           scanned when the circle is wholly off screen
//   read  : two row reads on the single read port
//   other : no work before the result
// Items are taken one at a time; a new item is accepted while the previous
// result still waits in the output register. When the receiver stalls, a
// finished item waits until that register is free.
// After reset the frame store is cleared by a pass over every row, during
// which no item is accepted; the radius resets to 16.0 pixels.
module circle_fill_framebuffer #(
    parameter int FB_WIDTH  = cff_pkg::FB_WIDTH_DEF,
    parameter int FB_HEIGHT = cff_pkg::FB_HEIGHT_DEF,
    parameter int FRAC_BITS = cff_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: radius
    input  logic        i_cfg_we,
    input  logic [9:0]  i_cfg_wdata,
    // commands
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [0] fill_value, [13:1] center_x, [26:14] center_y, [32:27] column,
    // [37:33] row_pair, [39:38] zero
    input  logic [39:0] i_s_axis_tdata,
    // [1:0] opcode
    input  logic [1:0]  i_s_axis_tuser,
    // results
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] char_code, [9:8] cell_bits, [15:10] zero
    output logic [15:0] o_m_axis_tdata
);

    localparam int CW   = cff_pkg::CENTER_W;
    localparam int XW   = $clog2(FB_WIDTH);
    localparam int YW   = $clog2(FB_HEIGHT);
    localparam int CIW  = (XW > YW) ? XW : YW;
    localparam int SW   = CW + 2;
    localparam int MAGW = $clog2(cff_pkg::RADIUS_MAX + (1 << FRAC_BITS)
                                 + (1 << (FRAC_BITS - 1)) + 1);
    localparam int RRW  = 2 * cff_pkg::RADIUS_W;
    localparam int SQW  = 2 * MAGW;
    localparam int CLW  = ((cff_pkg::COLUMN_W > XW) ? cff_pkg::COLUMN_W : XW) + 1;
    localparam int RLW  = ((cff_pkg::ROWP_W + 1 > YW) ? cff_pkg::ROWP_W + 1 : YW) + 1;

    localparam logic [XW-1:0] XLAST = XW'(FB_WIDTH - 1);
    localparam logic [YW-1:0] YLAST = YW'(FB_HEIGHT - 1);
    localparam logic signed [SW-1:0] SXMAX = SW'(FB_WIDTH - 1);
    localparam logic signed [SW-1:0] SYMAX = SW'(FB_HEIGHT - 1);
    localparam logic signed [SW-1:0] RND   = SW'((1 << FRAC_BITS) - 1);

    cff_pkg::t_state r_state, n_state;

    // command registers
    logic [cff_pkg::RADIUS_W-1:0] r_radius;
    logic [1:0]                   r_op;
    logic                         r_fill;
    logic                         r_init;
    logic signed [CW-1:0]         r_cx, r_cy;
    logic [cff_pkg::COLUMN_W-1:0] r_col;
    logic [cff_pkg::ROWP_W-1:0]   r_rp;

    // scan registers
    logic [XW-1:0]       r_bx, r_ex, r_x, r_s1_x;
    logic [YW-1:0]       r_by, r_ey, r_y;
    logic                r_empty;
    logic [RRW-1:0]      r_rr;
    logic [SQW-1:0]      r_dy2;
    logic                r_s1_valid;
    logic [FB_WIDTH-1:0] r_row, n_row;

    // read and result registers
    logic                       r_top;
    logic [cff_pkg::BITS_W-1:0] r_res_bits;
    logic                       r_out_valid;
    logic [cff_pkg::CHAR_W-1:0] r_out_char;
    logic [cff_pkg::BITS_W-1:0] r_out_bits;

    logic                s_fire;
    logic                out_free;
    cff_pkg::t_mem_ctl   mem_ctl;
    logic [YW-1:0]       mem_raddr;
    logic [FB_WIDTH-1:0] mem_wdata, mem_rdata;
    logic [CIW-1:0]      du_coord;
    logic signed [CW-1:0] du_center;
    logic [SQW-1:0]      du_sq;
    logic                hit;

    logic signed [SW-1:0] lo_x, hi_x, lo_y, hi_y;
    logic                 box_empty;
    logic [XW-1:0]        box_bx, box_ex;
    logic [YW-1:0]        box_by, box_ey;

    logic [CLW-1:0] col_ext;
    logic [RLW-1:0] top_ext, bot_ext;
    logic           col_ok, top_ok, bot_ok;
    logic [XW-1:0]  col_idx;

    assign s_fire   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;

    // bounding box of the circle, clipped to the screen
    always_comb begin
        lo_x = ($signed({{2{r_cx[CW-1]}}, r_cx}) - $signed(SW'(r_radius))) >>> FRAC_BITS;
        hi_x = ($signed({{2{r_cx[CW-1]}}, r_cx}) + $signed(SW'(r_radius)) + RND)
               >>> FRAC_BITS;
        lo_y = ($signed({{2{r_cy[CW-1]}}, r_cy}) - $signed(SW'(r_radius))) >>> FRAC_BITS;
        hi_y = ($signed({{2{r_cy[CW-1]}}, r_cy}) + $signed(SW'(r_radius)) + RND)
               >>> FRAC_BITS;
        box_empty = (lo_x > SXMAX) || (hi_x < 0) || (lo_y > SYMAX) || (hi_y < 0);
        box_bx = (lo_x < 0) ? '0 : lo_x[XW-1:0];
        box_by = (lo_y < 0) ? '0 : lo_y[YW-1:0];
        box_ex = (hi_x > SXMAX) ? XLAST : hi_x[XW-1:0];
        box_ey = (hi_y > SYMAX) ? YLAST : hi_y[YW-1:0];
    end

    // cell coordinates and on-screen checks
    always_comb begin
        col_ext = CLW'(r_col);
        top_ext = RLW'({r_rp, 1'b0});
        bot_ext = RLW'({r_rp, 1'b1});
        col_ok  = col_ext < CLW'(FB_WIDTH);
        top_ok  = top_ext < RLW'(FB_HEIGHT);
        bot_ok  = bot_ext < RLW'(FB_HEIGHT);
        col_idx = col_ext[XW-1:0];
    end

    // distance test of the pixel in flight and the updated row
    always_comb begin
        hit   = r_s1_valid && ((SQW+1)'(du_sq) + (SQW+1)'(r_dy2) <= (SQW+1)'(r_rr));
        n_row = r_row;
        if (hit) begin
            n_row[r_s1_x] = 1'b1;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cff_pkg::S_IDLE: begin
                if (s_fire) begin
                    case (i_s_axis_tuser)
                        cff_pkg::OP_CLEAR: n_state = cff_pkg::S_CLEAR;
                        cff_pkg::OP_DRAW:  n_state = cff_pkg::S_DRAW_SETUP;
                        cff_pkg::OP_READ:  n_state = cff_pkg::S_RD_TOP;
                        default:           n_state = cff_pkg::S_DONE;
                    endcase
                end
            end
            cff_pkg::S_CLEAR: begin
                if (r_y == YLAST) begin
                    n_state = r_init ? cff_pkg::S_IDLE : cff_pkg::S_DONE;
                end
            end
            cff_pkg::S_DRAW_SETUP: n_state = cff_pkg::S_DRAW_CHECK;
            cff_pkg::S_DRAW_CHECK: begin
                n_state = r_empty ? cff_pkg::S_DONE : cff_pkg::S_ROW_RD;
            end
            cff_pkg::S_ROW_RD:   n_state = cff_pkg::S_ROW_LOAD;
            cff_pkg::S_ROW_LOAD: n_state = cff_pkg::S_ROW_SCAN;
            cff_pkg::S_ROW_SCAN: begin
                if (r_x == r_ex) begin
                    n_state = cff_pkg::S_ROW_WB;
                end
            end
            cff_pkg::S_ROW_WB: begin
                n_state = (r_y == r_ey) ? cff_pkg::S_DONE : cff_pkg::S_ROW_RD;
            end
            cff_pkg::S_RD_TOP:  n_state = cff_pkg::S_RD_BOT;
            cff_pkg::S_RD_BOT:  n_state = cff_pkg::S_RD_LAST;
            cff_pkg::S_RD_LAST: n_state = cff_pkg::S_DONE;
            cff_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = cff_pkg::S_IDLE;
                end
            end
            default: n_state = cff_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer: input ready, memory port and distance unit operands
    always_comb begin
        o_s_axis_tready = 1'b0;
        mem_ctl         = '0;
        mem_raddr       = r_y;
        mem_wdata       = n_row;
        du_coord        = CIW'(r_x);
        du_center       = r_cx;
        case (r_state)
            cff_pkg::S_IDLE: o_s_axis_tready = 1'b1;
            cff_pkg::S_CLEAR: begin
                mem_ctl.we = 1'b1;
                mem_wdata  = {FB_WIDTH{r_fill}};
            end
            cff_pkg::S_ROW_RD: begin
                mem_ctl.re = 1'b1;
                du_coord   = CIW'(r_y);
                du_center  = r_cy;
            end
            cff_pkg::S_ROW_WB: mem_ctl.we = 1'b1;
            cff_pkg::S_RD_TOP: begin
                mem_ctl.re = 1'b1;
                mem_raddr  = top_ext[YW-1:0];
            end
            cff_pkg::S_RD_BOT: begin
                mem_ctl.re = 1'b1;
                mem_raddr  = bot_ext[YW-1:0];
            end
            default: ;
        endcase
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cff_pkg::S_CLEAR;
            r_init      <= 1'b1;
            r_fill      <= 1'b0;
            r_y         <= '0;
            r_radius    <= cff_pkg::RADIUS_RESET;
            r_out_valid <= 1'b0;
            r_s1_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_s1_valid <= (r_state == cff_pkg::S_ROW_SCAN);
            if (i_cfg_we) begin
                r_radius <= i_cfg_wdata;
            end
            if (s_fire) begin
                r_fill <= i_s_axis_tdata[0];
                r_y    <= '0;
            end
            case (r_state)
                cff_pkg::S_CLEAR: begin
                    r_y <= r_y + 1'b1;
                    if (r_y == YLAST) begin
                        r_init <= 1'b0;
                    end
                end
                cff_pkg::S_DRAW_CHECK: r_y <= r_by;
                cff_pkg::S_ROW_WB:     r_y <= r_y + 1'b1;
                default: ;
            endcase
            if (r_state == cff_pkg::S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_op       <= i_s_axis_tuser;
            r_cx       <= i_s_axis_tdata[13:1];
            r_cy       <= i_s_axis_tdata[26:14];
            r_col      <= i_s_axis_tdata[32:27];
            r_rp       <= i_s_axis_tdata[37:33];
            r_res_bits <= '0;
        end
        case (r_state)
            cff_pkg::S_DRAW_SETUP: begin
                r_rr    <= RRW'(r_radius) * RRW'(r_radius);
                r_empty <= box_empty;
                r_bx    <= box_bx;
                r_ex    <= box_ex;
                r_by    <= box_by;
                r_ey    <= box_ey;
            end
            cff_pkg::S_ROW_LOAD: begin
                r_row <= mem_rdata;
                r_dy2 <= du_sq;
                r_x   <= r_bx;
            end
            cff_pkg::S_ROW_SCAN: begin
                r_row  <= n_row;
                r_s1_x <= r_x;
                r_x    <= r_x + 1'b1;
            end
            cff_pkg::S_RD_BOT:  r_top <= top_ok && col_ok && mem_rdata[col_idx];
            cff_pkg::S_RD_LAST: begin
                if (r_op == cff_pkg::OP_READ) begin
                    r_res_bits <= {r_top, bot_ok && col_ok && mem_rdata[col_idx]};
                end
            end
            default: ;
        endcase
        if (r_state == cff_pkg::S_DONE && out_free) begin
            r_out_bits <= r_res_bits;
            r_out_char <= (r_op == cff_pkg::OP_READ) ? cff_pkg::cell_char(r_res_bits) : '0;
        end
    end

    cff_frame_mem #(
        .FB_WIDTH  (FB_WIDTH),
        .FB_HEIGHT (FB_HEIGHT),
        .AW        (YW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_waddr (r_y),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    cff_dist_sq #(
        .CIW       (CIW),
        .FRAC_BITS (FRAC_BITS),
        .MAGW      (MAGW)
    ) u_dist (
        .i_clk    (i_clk),
        .i_coord  (du_coord),
        .i_center (du_center),
        .o_sq     (du_sq)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out_bits, r_out_char};

    // the store is only written by a clear sweep or a row write-back
    a_write_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_ctl.we |-> (r_state == cff_pkg::S_CLEAR || r_state == cff_pkg::S_ROW_WB))
        else $error("frame store written outside clear or write-back");

    // scan column stays inside the clipped box
    a_scan_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cff_pkg::S_ROW_SCAN) |-> (r_x >= r_bx && r_x <= r_ex))
        else $error("scan column outside bounding box");

    // a pixel in flight is folded in before or during the write-back
    a_s1_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (r_state == cff_pkg::S_ROW_SCAN || r_state == cff_pkg::S_ROW_WB))
        else $error("distance result arrived outside a row scan");

    // one item at a time: nothing accepted in the cycle after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> !o_s_axis_tready)
        else $error("second item accepted while one is in progress");

    // a row write-back keeps the row that was read and only adds pixels
    a_row_adds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cff_pkg::S_ROW_WB) |-> ((mem_wdata & r_row) == r_row))
        else $error("row write-back lost a set pixel");

endmodule

/* rtl/cff_frame_mem.sv */
// row-wide frame store, one write port and one registered read port
module cff_frame_mem #(
    parameter int FB_WIDTH  = cff_pkg::FB_WIDTH_DEF,
    parameter int FB_HEIGHT = cff_pkg::FB_HEIGHT_DEF,
    parameter int AW        = $clog2(FB_HEIGHT)
) (
    input  logic                i_clk,
    input  cff_pkg::t_mem_ctl   i_ctl,
    input  logic [AW-1:0]       i_waddr,
    input  logic [FB_WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]       i_raddr,
    output logic [FB_WIDTH-1:0] o_rdata
);

    logic [FB_WIDTH-1:0] r_mem [FB_HEIGHT];
    logic [FB_WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/cff_dist_sq.sv */
// squared distance from a pixel centre to the circle centre along one axis
module cff_dist_sq #(
    parameter int CIW       = 6,
    parameter int FRAC_BITS = cff_pkg::FRAC_BITS_DEF,
    parameter int MAGW      = 11
) (
    input  logic                          i_clk,
    input  logic [CIW-1:0]                i_coord,
    input  logic signed [cff_pkg::CENTER_W-1:0] i_center,
    output logic [2*MAGW-1:0]             o_sq
);

    localparam int CW  = cff_pkg::CENTER_W;
    localparam int PW  = CIW + FRAC_BITS + 1;
    localparam int DW  = ((CW > PW) ? CW : PW) + 1;

    logic [DW-1:0]        pos;
    logic signed [DW-1:0] diff;
    logic [DW-1:0]        mag_full;
    logic [MAGW-1:0]      mag;
    logic [2*MAGW-1:0]    r_sq;

    // pixel centre coord + 0.5 in fixed point, then |centre - pixel|
    always_comb begin
        pos      = DW'({i_coord, 1'b1}) << (FRAC_BITS - 1);
        diff     = $signed({{(DW-CW){i_center[CW-1]}}, i_center}) - $signed(pos);
        mag_full = diff[DW-1] ? DW'(-diff) : DW'(diff);
        mag      = mag_full[MAGW-1:0];
    end

    // registered square
    always_ff @(posedge i_clk) begin
        r_sq <= (2*MAGW)'(mag) * (2*MAGW)'(mag);
    end

    assign o_sq = r_sq;

endmodule

/* tb/sv/tb_top.sv */
// self-checking testbench for the circle fill framebuffer: scene stimulus, cell prediction
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [cff_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam longint ONE_PX   = longint'(1) << cff_pkg::FRAC_BITS_DEF;
    localparam longint HALF_PX  = ONE_PX / 2;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 55;
    localparam int NUM_PHASES   = 10;

    typedef struct packed {
        logic [cff_pkg::CHAR_W-1:0] char_code;
        logic [cff_pkg::BITS_W-1:0] cell_bits;
    } t_cell_result;

    // mirror of the frame store and the queue of cells still to come back
    class frame_tracker;
        bit pix [cff_pkg::FB_HEIGHT_DEF][cff_pkg::FB_WIDTH_DEF];
        logic [cff_pkg::RADIUS_W-1:0] radius;
        t_cell_result pending_cells[$];
        int mismatches;

        function new();
            foreach (pix[y, x]) pix[y][x] = 1'b0;
            radius = cff_pkg::RADIUS_RESET;
            mismatches = 0;
        endfunction

        function int pending();
            return pending_cells.size();
        endfunction

        // apply one accepted command and queue the cell it returns
        function void take_command(logic [cff_pkg::OPCODE_W-1:0] op, logic [39:0] data);
            t_cell_result res;
            logic signed [cff_pkg::CENTER_W-1:0] cx13, cy13;
            longint cx, cy, r, rr, bx, by, ex, ey, dx, dy, px, py;
            int col, top_row;
            logic [cff_pkg::BITS_W-1:0] bits;
            res = '0;
            case (op)
                cff_pkg::OP_CLEAR: begin
                    foreach (pix[y, x]) pix[y][x] = data[0];
                end
                cff_pkg::OP_DRAW: begin
                    cx13 = data[13:1];
                    cy13 = data[26:14];
                    cx = cx13;
                    cy = cy13;
                    r = longint'(radius);
                    rr = r * r;
                    // bounding box in whole pixels, then clipped to the screen
                    bx = (cx - r) >>> cff_pkg::FRAC_BITS_DEF;
                    by = (cy - r) >>> cff_pkg::FRAC_BITS_DEF;
                    ex = (cx + r + ONE_PX - 1) >>> cff_pkg::FRAC_BITS_DEF;
                    ey = (cy + r + ONE_PX - 1) >>> cff_pkg::FRAC_BITS_DEF;
                    if (bx < 0) bx = 0;
                    if (by < 0) by = 0;
                    if (ex > cff_pkg::FB_WIDTH_DEF - 1) ex = cff_pkg::FB_WIDTH_DEF - 1;
                    if (ey > cff_pkg::FB_HEIGHT_DEF - 1) ey = cff_pkg::FB_HEIGHT_DEF - 1;
                    for (py = by; py <= ey; py++) begin
                        dy = cy - (py * ONE_PX + HALF_PX);
                        for (px = bx; px <= ex; px++) begin
                            dx = cx - (px * ONE_PX + HALF_PX);
                            if (dx * dx + dy * dy <= rr) pix[py][px] = 1'b1;
                        end
                    end
                end
                cff_pkg::OP_READ: begin
                    col = int'(data[32:27]);
                    top_row = 2 * int'(data[37:33]);
                    bits = {pix[top_row][col], pix[top_row + 1][col]};
                    res.cell_bits = bits;
                    case (bits)
                        2'd0:    res.char_code = cff_pkg::CH_SPACE;
                        2'd1:    res.char_code = cff_pkg::CH_UNDER;
                        2'd2:    res.char_code = cff_pkg::CH_CARET;
                        default: res.char_code = cff_pkg::CH_FULL;
                    endcase
                end
                default: ;
            endcase
            pending_cells.push_back(res);
        endfunction

        // compare one returned item against the oldest queued cell
        function void compare_cell(logic [15:0] tdata);
            t_cell_result want;
            if (pending_cells.size() == 0) begin
                $display("%0t: result item with nothing queued, actual %h", $time, tdata);
                mismatches++;
                return;
            end
            want = pending_cells.pop_front();
            if (tdata[7:0] !== want.char_code || tdata[9:8] !== want.cell_bits) begin
                $display("%0t: cell differs, expected char %0d bits %0d, actual char %0d bits %0d",
                         $time, want.char_code, want.cell_bits, tdata[7:0], tdata[9:8]);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [9:0]  i_cfg_wdata = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata = '0;
    logic [1:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;

    frame_tracker tracker;
    int cmds_sent = 0;
    bit no_idle = 1'b0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;

    circle_fill_framebuffer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        // [0] fill_value, [13:1] center_x, [26:14] center_y, [32:27] column,
        // [37:33] row_pair, [39:38] zero
        .i_s_axis_tdata  (i_s_axis_tdata),
        // [1:0] opcode
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        // [7:0] char_code, [9:8] cell_bits, [15:10] zero
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // run limit, far above the slowest correct run
    initial begin
        #(100_000_000);
        $display("circle_fill_framebuffer: mismatch");
        $finish;
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) tracker.compare_cell(o_m_axis_tdata);
    end

    // receiver: random stalls plus one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 7);
        end
    end

    function automatic logic [39:0] pack_cmd(logic fill, logic [cff_pkg::CENTER_W-1:0] cx,
                                             logic [cff_pkg::CENTER_W-1:0] cy,
                                             logic [cff_pkg::COLUMN_W-1:0] col,
                                             logic [cff_pkg::ROWP_W-1:0] rp);
        return {2'b00, rp, col, cy, cx, fill};
    endfunction

    // offer one command item and wait for it to be taken
    task automatic send_cmd(input logic [cff_pkg::OPCODE_W-1:0] op, input logic [39:0] data);
        if (!no_idle) begin
            while ($urandom_range(0, 99) < 7) begin
                i_s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= data;
        i_s_axis_tuser <= op;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        tracker.take_command(op, data);
        cmds_sent++;
    endtask

    task automatic send_read(input int col, input int rp);
        send_cmd(cff_pkg::OP_READ, pack_cmd(1'b0, '0, '0, cff_pkg::COLUMN_W'(col),
                 cff_pkg::ROWP_W'(rp)));
    endtask

    task automatic send_draw(input int cx, input int cy);
        send_cmd(cff_pkg::OP_DRAW, pack_cmd(1'b0, cff_pkg::CENTER_W'(cx),
                 cff_pkg::CENTER_W'(cy), '0, '0));
    endtask

    task automatic send_clear(input logic fill);
        send_cmd(cff_pkg::OP_CLEAR, pack_cmd(fill, '0, '0, '0, '0));
    endtask

    // stop offering and wait for every queued cell to come back
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_radius(input int value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= cff_pkg::RADIUS_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.radius = cff_pkg::RADIUS_W'(value);
    endtask

    // clear, a few circles mostly on screen, then reads around the last one
    task automatic run_scene();
        int n_draw, n_read, span, cxi, cyi, k, rowi;
        logic [cff_pkg::COLUMN_W-1:0] col;
        logic [5:0] row6;
        n_draw = $urandom_range(1, 3);
        n_read = $urandom_range(4, 10);
        cxi = 0;
        cyi = 0;
        send_cmd(cff_pkg::OP_CLEAR, pack_cmd($urandom_range(0, 99) < 15,
                 cff_pkg::CENTER_W'($urandom), cff_pkg::CENTER_W'($urandom),
                 cff_pkg::COLUMN_W'($urandom), cff_pkg::ROWP_W'($urandom)));
        for (k = 0; k < n_draw; k++) begin
            cxi = int'($urandom_range(0, 1151)) - 64;
            cyi = int'($urandom_range(0, 1151)) - 64;
            // half the centres sit on a pixel centre, which matters for tiny radii
            if ($urandom_range(0, 1) == 1) begin
                cxi = (cxi & ~15) | 8;
                cyi = (cyi & ~15) | 8;
            end
            send_cmd(cff_pkg::OP_DRAW, pack_cmd(1'($urandom), cff_pkg::CENTER_W'(cxi),
                     cff_pkg::CENTER_W'(cyi), cff_pkg::COLUMN_W'($urandom),
                     cff_pkg::ROWP_W'($urandom)));
        end
        span = int'(tracker.radius >> cff_pkg::FRAC_BITS_DEF) + 2;
        if (span > 40) span = 40;
        for (k = 0; k < n_read; k++) begin
            col = cff_pkg::COLUMN_W'((cxi >>> cff_pkg::FRAC_BITS_DEF)
                  + int'($urandom_range(0, 2 * span)) - span);
            rowi = (cyi >>> cff_pkg::FRAC_BITS_DEF) + int'($urandom_range(0, 2 * span)) - span;
            row6 = 6'(rowi);
            send_cmd(cff_pkg::OP_READ, pack_cmd(1'($urandom), cff_pkg::CENTER_W'($urandom),
                     cff_pkg::CENTER_W'($urandom), col, row6[5:1]));
        end
    endtask

    // main sequence
    initial begin
        int ph, rad, phase_start;
        int radii [NUM_PHASES];
        radii = '{0, 1023, 8, 512, 17, 0, 0, 0, 0, 0};
        tracker = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty screen, unused opcode, circle edges, off-screen circles, fills
        send_read(0, 0);
        send_read(63, 31);
        send_cmd(OP_UNUSED, {2'b00, {38{1'b1}}});
        send_draw(512, 528);
        send_read(32, 16);
        send_read(32, 8);
        send_read(32, 24);
        send_read(16, 16);
        send_read(15, 16);
        send_draw(-4096, -4096);
        send_draw(4095, 4095);
        send_read(63, 31);
        send_draw(0, 0);
        send_read(0, 0);
        send_clear(1'b1);
        send_read(5, 5);
        send_cmd(OP_UNUSED, 40'd0);
        send_read(5, 5);
        send_clear(1'b0);
        send_read(0, 0);

        // random phases, each at its own radius
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            rad = (ph < 5) ? radii[ph] : int'($urandom_range(1, 96));
            write_radius(rad);
            no_idle = (ph == 4);
            if (ph == 0) begin
                // zero radius: hit only on an exact pixel centre
                send_draw(168, 168);
                send_read(10, 5);
                send_draw(400, 400);
                send_read(25, 12);
                send_read(24, 12);
            end
            phase_start = cmds_sent;
            while (cmds_sent < phase_start + PHASE_ITEMS) begin
                if (ph == 2 && !hold_req && cmds_sent >= phase_start + 20) hold_req = 1'b1;
                if ($urandom_range(0, 99) < 75) begin
                    run_scene();
                end else begin
                    // noise: any opcode, any field content
                    send_cmd(cff_pkg::OPCODE_W'($urandom), {2'b00, 6'($urandom), 32'($urandom)});
                end
            end
            no_idle = 1'b0;
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("circle_fill_framebuffer: match");
        end else begin
            $display("circle_fill_framebuffer: mismatch");
        end
        $finish;
    end

endmodule
